FILE: sv/alr_pkg.sv
// Package for the anti-aliased line rasterizer.
// Holds the shared constants, the sequencer state type, the status structs and
// the coordinate rounding helper. Depends on nothing.
package alr_pkg;

	localparam int MAX_COLUMNS     = 64;
	localparam int COORD_FRAC_BITS = 4;
	localparam int COORD_W         = 16;
	localparam int PIX_W           = 12;
	localparam int ALPHA_W         = 8;
	localparam int GRAD_FRAC       = 16;
	localparam int QUOT_W          = GRAD_FRAC + 1;
	localparam int DIV_STEPS       = QUOT_W;
	localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
	localparam int ACC_W           = 30;
	localparam int COL_W           = $clog2(MAX_COLUMNS);
	localparam int FRAC_MASK       = (1 << COORD_FRAC_BITS) - 1;
	localparam int MAJ_W           = COORD_W - COORD_FRAC_BITS + 1;
	localparam int PROD_W          = ALPHA_W + GRAD_FRAC;
	localparam int IN_DATA_W       = 72;
	localparam int OUT_DATA_W      = 48;
	localparam int OUT_USER_W      = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_INIT,
		ST_POINT,
		ST_COL
	} state_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_res_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] first;
		logic [ALPHA_W-1:0] second;
		logic               show_second;
	} alpha_t;

	// Rounds a fixed-point coordinate to whole pixels, ties to even, wrapped to PIX_W bits.
	function automatic logic [PIX_W-1:0] round_coord(input logic signed [COORD_W-1:0] v);
		logic signed [COORD_W-1:0]      q;
		logic [COORD_FRAC_BITS-1:0]     r;
		logic                           inc;
		q = v >>> COORD_FRAC_BITS;
		r = v[COORD_FRAC_BITS-1:0];
		inc = (r > COORD_FRAC_BITS'(1 << (COORD_FRAC_BITS - 1))) ||
			((r == COORD_FRAC_BITS'(1 << (COORD_FRAC_BITS - 1))) && q[0]);
		return PIX_W'(q) + PIX_W'(inc);
	endfunction

endpackage

FILE: sv/alr_div.sv
// Iterative restoring divider for the line gradient, one quotient bit per cycle.
// Computes (dividend << 16) / divisor for dividend <= divisor. Uses alr_pkg.
module alr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [alr_pkg::COORD_W-1:0] dividend,
	input  logic [alr_pkg::COORD_W-1:0] divisor,
	output alr_pkg::div_res_t           res
);
	import alr_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [COORD_W-1:0]   rem_q;
	logic                 bit_q;
	logic [QUOT_W-1:0]    quot_q;
	logic [COORD_W:0]     trial;
	logic [COORD_W:0]     diff;
	logic                 ge;

	assign trial = {rem_q, bit_q};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The partial remainder always stays below the divisor, so it fits the divisor width.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[COORD_W-1:1]};
			bit_q <= dividend[0];
		end else if (busy_q) begin
			rem_q  <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
			bit_q  <= 1'b0;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule

FILE: sv/alr_alpha.sv
// Coverage unit: splits the base alpha between the two pixels of a pair.
// One 8 by 16 multiply and round-to-even on the minor fraction. Uses alr_pkg.
module alr_alpha (
	input  logic [alr_pkg::ALPHA_W-1:0]   base,
	input  logic [alr_pkg::GRAD_FRAC-1:0] frac,
	output alr_pkg::alpha_t               alpha
);
	import alr_pkg::*;

	logic [PROD_W-1:0]    p;
	logic [PROD_W-1:0]    m;
	logic [GRAD_FRAC-1:0] half;
	logic                 up2;
	logic                 up1;

	assign half = GRAD_FRAC'(1) << (GRAD_FRAC - 1);
	assign p    = PROD_W'(base) * PROD_W'(frac);
	assign m    = {base, GRAD_FRAC'(0)} - p;

	assign up2 = (p[GRAD_FRAC-1:0] > half) ||
		((p[GRAD_FRAC-1:0] == half) && p[GRAD_FRAC]);
	assign up1 = (m[GRAD_FRAC-1:0] > half) ||
		((m[GRAD_FRAC-1:0] == half) && m[GRAD_FRAC]);

	// Neither sum can pass 255: with a nonzero fraction each integer part is at most 254.
	assign alpha.second      = p[PROD_W-1:GRAD_FRAC] + ALPHA_W'(up2);
	assign alpha.first       = m[PROD_W-1:GRAD_FRAC] + ALPHA_W'(up1);
	assign alpha.show_second = frac != '0;

endmodule

FILE: sv/antialiased_line_raster.sv
// Anti-aliased line rasterizer top level: sequencer, setup, accumulator and output word.
// Uses alr_pkg, alr_div (gradient divider) and alr_alpha (coverage unit).
//
// One input word describes a line segment with Q12.4 endpoints and a base alpha. The block
// takes it, picks the major axis, orders the endpoints, then runs one restoring division
// for the gradient, and after that walks the whole major columns from the rounded-up start
// to the rounded-down end, one output word per column and per cycle while the output side
// keeps taking them. Before its walk each segment passes through capture, setup, division
// and walk start. A segment whose endpoints share a major coordinate skips the division
// and gives one pixel with the base alpha.
// A segment that covers no whole column gives no word at all. At most MAX_COLUMNS words
// come out of one segment; a longer segment is cut and every word carries the cut flag.
// s_tready is high only while the sequencer is idle, but a finished word may still wait
// in the output register then, so a new segment can enter before the last word is taken.
module antialiased_line_raster (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48], base_alpha[71:64]
	input  logic [alr_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pixel_x[11:0], pixel_y[23:12], alpha_first[31:24], alpha_second[39:32],
	// show_first[40], show_second[41], zero[47:42]
	output logic [alr_pkg::OUT_DATA_W-1:0]    m_tdata,
	// steep_pair[0], was_cut[1]
	output logic [alr_pkg::OUT_USER_W-1:0]    m_tuser,
	// last_column
	output logic                              m_tlast
);
	import alr_pkg::*;

	state_t state_q, state_d;

	// Captured input word.
	logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [ALPHA_W-1:0]        base_q;

	// Endpoints after the axis swap and ordering.
	logic signed [COORD_W-1:0] mx1_q, my1_q, mx2_q;
	logic                      steep_q;
	logic                      dyneg_q;

	// Column walk.
	logic signed [ACC_W-1:0]   y_q;
	logic signed [QUOT_W:0]    g_q;
	logic [PIX_W-1:0]          col_q;
	logic [COL_W-1:0]          k_q;
	logic [COL_W-1:0]          last_k_q;
	logic                      cut_q;

	// Output word.
	logic                      m_tvalid_q;
	logic [OUT_DATA_W-1:0]     m_tdata_q;
	logic [OUT_USER_W-1:0]     m_tuser_q;
	logic                      m_tlast_q;

	// Setup logic.
	logic signed [COORD_W:0]   dxo_w, dyo_w, dyd_w;
	logic [COORD_W-1:0]        adx_w, ady_w, dx_w, adym_w;
	logic                      steep_w, swap_w;
	logic signed [COORD_W-1:0] ax1_w, ay1_w, ax2_w, ay2_w;
	logic signed [COORD_W-1:0] mx1_w, my1_w, mx2_w, my2_w;

	// Column setup logic.
	logic signed [QUOT_W:0]                   g_w;
	logic [COORD_FRAC_BITS-1:0]               c_w;
	logic signed [QUOT_W+COORD_FRAC_BITS+1:0] prod_w;
	logic signed [ACC_W-1:0]                  y0_w;
	logic signed [COORD_W:0]                  sxr_w;
	logic signed [MAJ_W-1:0]                  start_w, end_w;
	logic signed [MAJ_W:0]                    span_w;
	logic                                     cut_w;
	logic [COL_W-1:0]                         last_k_w;

	logic                      out_load;
	logic                      div_start;
	div_res_t                  div_res;
	alpha_t                    alpha;
	logic [PIX_W-1:0]          yi_w;

	// Pick the major axis and order the endpoints so that the major coordinate rises.
	always_comb begin
		dxo_w   = (COORD_W+1)'(ex_q) - (COORD_W+1)'(sx_q);
		dyo_w   = (COORD_W+1)'(ey_q) - (COORD_W+1)'(sy_q);
		adx_w   = COORD_W'(dxo_w[COORD_W] ? -dxo_w : dxo_w);
		ady_w   = COORD_W'(dyo_w[COORD_W] ? -dyo_w : dyo_w);
		steep_w = ady_w > adx_w;
		ax1_w   = steep_w ? sy_q : sx_q;
		ay1_w   = steep_w ? sx_q : sy_q;
		ax2_w   = steep_w ? ey_q : ex_q;
		ay2_w   = steep_w ? ex_q : ey_q;
		swap_w  = ax1_w > ax2_w;
		mx1_w   = swap_w ? ax2_w : ax1_w;
		my1_w   = swap_w ? ay2_w : ay1_w;
		mx2_w   = swap_w ? ax1_w : ax2_w;
		my2_w   = swap_w ? ay1_w : ay2_w;
		dx_w    = COORD_W'((COORD_W+1)'(mx2_w) - (COORD_W+1)'(mx1_w));
		dyd_w   = (COORD_W+1)'(my2_w) - (COORD_W+1)'(my1_w);
		adym_w  = COORD_W'(dyd_w[COORD_W] ? -dyd_w : dyd_w);
	end

	// Start of the column walk: minor position at the first whole column and the column range.
	always_comb begin
		g_w      = dyneg_q ? -$signed({1'b0, div_res.quot}) : $signed({1'b0, div_res.quot});
		c_w      = COORD_FRAC_BITS'(~mx1_q[COORD_FRAC_BITS-1:0] + 1'b1);
		prod_w   = g_w * $signed({1'b0, c_w});
		y0_w     = (ACC_W'(my1_q) <<< (GRAD_FRAC - COORD_FRAC_BITS)) +
			ACC_W'(prod_w >>> COORD_FRAC_BITS);
		sxr_w    = (COORD_W+1)'(mx1_q) + (COORD_W+1)'(FRAC_MASK);
		start_w  = MAJ_W'(sxr_w >>> COORD_FRAC_BITS);
		end_w    = MAJ_W'(mx2_q >>> COORD_FRAC_BITS);
		span_w   = (MAJ_W+1)'(end_w) - (MAJ_W+1)'(start_w);
		cut_w    = span_w >= (MAJ_W+1)'(MAX_COLUMNS);
		last_k_w = cut_w ? COL_W'(MAX_COLUMNS - 1) : span_w[COL_W-1:0];
	end

	assign out_load = !m_tvalid_q || m_tready;
	assign yi_w     = y_q[GRAD_FRAC +: PIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: capture, setup, divide, start the walk, then one column per free output slot, or one point word.
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (dx_w == '0) begin
					state_d = ST_POINT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_res.done) state_d = ST_INIT;
			end
			ST_INIT: begin
				state_d = span_w[MAJ_W] ? ST_IDLE : ST_COL;
			end
			ST_POINT: begin
				if (out_load) state_d = ST_IDLE;
			end
			ST_COL: begin
				if (out_load && (k_q == last_k_q)) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	alr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (adym_w),
		.divisor  (dx_w),
		.res      (div_res)
	);

	alr_alpha u_alpha (
		.base  (base_q),
		.frac  (y_q[GRAD_FRAC-1:0]),
		.alpha (alpha)
	);

	// Datapath registers.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && s_tvalid) begin
			sx_q   <= s_tdata[15:0];
			sy_q   <= s_tdata[31:16];
			ex_q   <= s_tdata[47:32];
			ey_q   <= s_tdata[63:48];
			base_q <= s_tdata[71:64];
		end
		if (state_q == ST_SETUP) begin
			mx1_q   <= mx1_w;
			my1_q   <= my1_w;
			mx2_q   <= mx2_w;
			steep_q <= steep_w;
			dyneg_q <= dyd_w[COORD_W];
		end
		if (state_q == ST_INIT) begin
			y_q      <= y0_w;
			g_q      <= g_w;
			col_q    <= start_w[PIX_W-1:0];
			k_q      <= '0;
			last_k_q <= last_k_w;
			cut_q    <= cut_w;
		end else if ((state_q == ST_COL) && out_load) begin
			y_q   <= y_q + ACC_W'(g_q);
			col_q <= col_q + 1'b1;
			k_q   <= k_q + 1'b1;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (((state_q == ST_POINT) || (state_q == ST_COL)) && out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_POINT) && out_load) begin
			m_tdata_q <= {6'b0, 1'b0, 1'b1, ALPHA_W'(0), base_q,
				round_coord(my1_q), round_coord(mx1_q)};
			m_tuser_q <= '0;
			m_tlast_q <= 1'b1;
		end else if ((state_q == ST_COL) && out_load) begin
			m_tdata_q <= {6'b0, alpha.show_second, 1'b1, alpha.second, alpha.first,
				steep_q ? col_q : yi_w, steep_q ? yi_w : col_q};
			m_tuser_q <= {cut_q, steep_q};
			m_tlast_q <= k_q == last_k_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// The first pixel of a pair is always marked shown.
	a_show_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40])
		else $error("first pixel of a word is not marked shown");

	// A hidden second pixel carries no alpha.
	a_hidden_second: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[41]) |-> (m_tdata[39:32] == '0))
		else $error("hidden second pixel has nonzero alpha");

	// The column counter never runs past the final column of the segment.
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COL) |-> (k_q <= last_k_q))
		else $error("column counter passed the final column");

	// The divider reports a result only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide step");

endmodule
